>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types for the circular deque unit: operation codes and the
// controller states.
// ----------------------------------------------------------------------------
package cdq_pkg;

   // Operation codes carried by an input beat.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_NO_CHANGE  = 3'd4
   } op_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

endpackage

>>> rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed items held in a ring whose size in use is
// set by a configuration register.
// ----------------------------------------------------------------------------
// A push, a refused operation, a no change, or a pop that empties the deque
// keeps busy low, and the result beat appears on the cycle after start. A
// pop that leaves items behind must first fetch the new front or rear item
// from the ring RAM, whose read data is registered; busy is high while the
// controller is in ST_READ, and the result beat is registered from it. The
// front and rear items are kept in registers, so a push never reads the RAM.
// The result beat is on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, and the receiver cannot stall it. Writing the capacity
// register empties the deque; it is taken whenever busy is low.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
   parameter int MAX_DEPTH  = 64,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // Command input.
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_operation,
   input  logic signed [ITEM_WIDTH-1:0] req_item_value,
   // Result output.
   output logic                         rsp_strobe,
   output logic                         rsp_accepted,
   output logic signed [ITEM_WIDTH-1:0] rsp_front_item,
   output logic signed [ITEM_WIDTH-1:0] rsp_rear_item,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   output logic [6:0]                   rsp_item_count,
   // Capacity register write.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [6:0]                   csr_data
);

   import cdq_pkg::*;

   localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
   localparam int RESET_CAP = (MAX_DEPTH < 64) ? MAX_DEPTH : 64;

   // Control state.
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] rear_ff, rear_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [ITEM_WIDTH-1:0] front_item_ff, front_item_in;
   logic [ITEM_WIDTH-1:0] rear_item_ff, rear_item_in;
   logic                  accepted_ff, accepted_in;
   logic                  pend_front_ff, pend_front_in;

   // RAM ports.
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   logic             fire;
   logic             csr_fire;
   logic             need_read;
   logic [CW-1:0]    csr_wide;
   logic [CNT_W-1:0] cap_new;
   logic [CW-1:0]    count_wide;

   // Ring pointer step up, wrapping at the capacity in use.
   function automatic logic [PTR_W-1:0] slot_up(input logic [PTR_W-1:0] s,
                                                input logic [CNT_W-1:0] cap);
      logic [CW:0] nxt;
      nxt = (CW + 1)'(s) + 1'b1;
      if (nxt >= (CW + 1)'(cap)) begin
         return '0;
      end
      return PTR_W'(nxt);
   endfunction

   // Ring pointer step down, wrapping to the top slot in use.
   function automatic logic [PTR_W-1:0] slot_down(input logic [PTR_W-1:0] s,
                                                  input logic [CNT_W-1:0] cap);
      if (s == '0) begin
         return PTR_W'(cap - 1'b1);
      end
      return s - 1'b1;
   endfunction

   assign fire     = start && !busy;
   assign csr_ready = !busy;
   assign csr_fire = csr_valid && csr_ready;

   // Clamp the written capacity into 1 .. MAX_DEPTH.
   always_comb begin
      csr_wide = CW'(csr_data);
      if (csr_wide == '0) begin
         cap_new = CNT_W'(1);
      end else if (csr_wide > CW'(MAX_DEPTH)) begin
         cap_new = CNT_W'(MAX_DEPTH);
      end else begin
         cap_new = CNT_W'(csr_wide);
      end
   end

   // Operation datapath: pointer and count update, RAM write and read issue.
   always_comb begin
      front_in      = front_ff;
      rear_in       = rear_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      front_item_in = front_item_ff;
      rear_item_in  = rear_item_ff;
      accepted_in   = accepted_ff;
      pend_front_in = pend_front_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      need_read     = 1'b0;

      if (fire) begin
         accepted_in = 1'b0;
         case (op_type'(req_operation))
            OP_PUSH_FRONT: begin
               if (count_ff < cap_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = front_ff;
                  front_in      = slot_up(front_ff, cap_ff);
                  count_in      = count_ff + 1'b1;
                  front_item_in = req_item_value;
                  if (count_ff == '0) begin
                     rear_item_in = req_item_value;
                  end
                  accepted_in = 1'b1;
               end
            end
            OP_PUSH_REAR: begin
               if (count_ff < cap_ff) begin
                  wr_en        = 1'b1;
                  wr_addr      = rear_ff;
                  rear_in      = slot_down(rear_ff, cap_ff);
                  count_in     = count_ff + 1'b1;
                  rear_item_in = req_item_value;
                  if (count_ff == '0) begin
                     front_item_in = req_item_value;
                  end
                  accepted_in = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (count_ff != '0) begin
                  front_in      = slot_down(front_ff, cap_ff);
                  count_in      = count_ff - 1'b1;
                  rd_addr       = slot_down(front_in, cap_ff);
                  need_read     = (count_ff > CNT_W'(1));
                  rd_en         = need_read;
                  pend_front_in = 1'b1;
                  accepted_in   = 1'b1;
               end
            end
            OP_POP_REAR: begin
               if (count_ff != '0) begin
                  rear_in       = slot_up(rear_ff, cap_ff);
                  count_in      = count_ff - 1'b1;
                  rd_addr       = slot_up(rear_in, cap_ff);
                  need_read     = (count_ff > CNT_W'(1));
                  rd_en         = need_read;
                  pend_front_in = 1'b0;
                  accepted_in   = 1'b1;
               end
            end
            OP_NO_CHANGE: begin
               accepted_in = 1'b1;
            end
            default: begin
               accepted_in = 1'b0;
            end
         endcase
      end

      // Fetched item lands in the cached front or rear register.
      if (state_ff == ST_READ) begin
         if (pend_front_ff) begin
            front_item_in = rd_data;
         end else begin
            rear_item_in = rd_data;
         end
      end

      // A capacity write empties the deque.
      if (csr_fire) begin
         cap_in   = cap_new;
         count_in = '0;
         front_in = '0;
         rear_in  = PTR_W'(cap_new - 1'b1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire && need_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      busy         = (state_ff == ST_READ);
      rsp_valid_in = (fire && !need_read) || (state_ff == ST_READ);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         rear_ff      <= PTR_W'(RESET_CAP - 1);
         count_ff     <= '0;
         cap_ff       <= CNT_W'(RESET_CAP);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      front_item_ff <= front_item_in;
      rear_item_ff  <= rear_item_in;
      accepted_ff   <= accepted_in;
      pend_front_ff <= pend_front_in;
   end

   // Ring storage.
   cdq_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (MAX_DEPTH),
      .ADDR_W(PTR_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_item_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Result beat: taken from the state left by the operation.
   assign count_wide     = CW'(count_ff);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_is_empty   = (count_ff == '0);
   assign rsp_is_full    = (count_ff == cap_ff);
   assign rsp_item_count = count_wide[6:0];
   assign rsp_front_item = (count_ff == '0) ? '1 : front_item_ff;
   assign rsp_rear_item  = (count_ff == '0) ? '1 : rear_item_ff;

endmodule
